// ===== sv/srs_pkg.sv =====
// shared types, constants and the symbol lookup for the radix symbol converter
package srs_pkg;

  // fixed field widths
  localparam int NUM_W         = 32;
  localparam int SYM_W         = 8;
  localparam int LEN_W         = 5;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 2;

  // symbol table geometry
  localparam int TABLE_SLOTS   = 16;
  localparam int SLOT_W        = 4;
  localparam int DEF_MAX_RADIX = 16;

  // digit stack depth: enough for radix two on a 32-bit magnitude
  localparam int DIGIT_SLOTS   = 32;

  // divider: quotient bits resolved per cycle
  localparam int DIV_BITS      = 8;
  localparam int DIV_STEPS     = NUM_W / DIV_BITS;
  localparam int STEP_W        = $clog2(DIV_STEPS);

  localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_LENGTH  = 2'd0,
    REG_SYMBOLS_LOW  = 2'd1,
    REG_SYMBOLS_HIGH = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;
    logic run;
  } div_ctrl_t;

  typedef struct packed {
    logic bad;
    logic last;
  } check_stat_t;

  // symbol byte for a digit value, low word holds digits 0 to 7
  function automatic logic [SYM_W-1:0] symbol_of(input logic [CFG_W-1:0] lo,
                                                 input logic [CFG_W-1:0] hi,
                                                 input logic [SLOT_W-1:0] slot);
    logic [2:0] k;
    k = slot[2:0];
    return slot[SLOT_W-1] ? hi[k*SYM_W +: SYM_W] : lo[k*SYM_W +: SYM_W];
  endfunction

endpackage

// ===== sv/srs_if.sv =====
// request channels for numbers in and symbols out
interface srs_in_if;
  import srs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface srs_out_if;
  import srs_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== sv/srs_divider.sv =====
// shared divider: magnitude by radix, several quotient bits per cycle
module srs_divider import srs_pkg::*; #(
  parameter int MaxRadix = DEF_MAX_RADIX
) (
  input  logic                         clk,
  input  logic                         rst,
  input  div_ctrl_t                    ctrl,
  input  logic [NUM_W-1:0]             dividend,
  input  logic [$clog2(MaxRadix):0]    radix,
  output logic [NUM_W-1:0]             quot,
  output logic [$clog2(MaxRadix)-1:0]  rem,
  output logic                         done
);

  localparam int DigitW = $clog2(MaxRadix);

  logic [STEP_W-1:0] cnt;
  logic [NUM_W-1:0]  quot_next;
  logic [DigitW-1:0] rem_next;

  // restoring division steps, remainder starts at zero on each new digit
  always_comb begin
    logic [DigitW:0]   t;
    logic [DigitW-1:0] r;
    logic [NUM_W-1:0]  a;
    a = quot;
    r = (cnt == '0) ? '0 : rem;
    for (int b = 0; b < DIV_BITS; b++) begin
      t = {r, a[NUM_W-1]};
      a = {a[NUM_W-2:0], 1'b0};
      if (t >= radix) begin
        t    = t - radix;
        a[0] = 1'b1;
      end
      r = t[DigitW-1:0];
    end
    quot_next = a;
    rem_next  = r;
  end

  // step counter and completion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (ctrl.load) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (ctrl.run) begin
      cnt  <= (cnt == STEP_W'(DIV_STEPS - 1)) ? '0 : cnt + 1'b1;
      done <= (cnt == STEP_W'(DIV_STEPS - 1));
    end else begin
      done <= 1'b0;
    end
  end

  // quotient and remainder
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quot <= dividend;
    end else if (ctrl.run) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

endmodule

// ===== sv/srs_base_check.sv =====
// base validity test for one table slot: length range, sign bytes and later slots
module srs_base_check import srs_pkg::*; #(
  parameter int MaxRadix = DEF_MAX_RADIX
) (
  input  logic [LEN_W-1:0]  base_length,
  input  logic [CFG_W-1:0]  symbols_low,
  input  logic [CFG_W-1:0]  symbols_high,
  input  logic [SLOT_W-1:0] slot,
  output check_stat_t       stat
);

  logic [SYM_W-1:0] sym;
  logic             len_bad;
  logic             sign_bad;
  logic             dup;

  assign sym      = symbol_of(symbols_low, symbols_high, slot);
  assign len_bad  = (base_length < LEN_W'(2)) || (base_length > LEN_W'(MaxRadix));
  assign sign_bad = (sym == SIGN_PLUS) || (sym == SIGN_MINUS);

  // compare with every later slot in use
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < TABLE_SLOTS; j++) begin
      if ((SLOT_W'(j) > slot) && (LEN_W'(j) < base_length) &&
          (symbol_of(symbols_low, symbols_high, SLOT_W'(j)) == sym)) begin
        dup = 1'b1;
      end
    end
  end

  assign stat.bad  = len_bad || sign_bad || dup;
  assign stat.last = ({1'b0, slot} == base_length - 1'b1);

endmodule

// ===== sv/signed_integer_to_radix_symbols_top.sv =====
// signed number to radix symbols: sequencer, digit stack and output register
//
//   channel     kind      payload              notes
//   number_ch   sink      number[31:0] signed  one number per request
//   symbol_ch   source    symbol[7:0], last    '-' then digits, msd first
//   cfg_*       write     index[1:0], 64 bits  length, low and high symbols
//
// a number is accepted while idle, then the base is checked slot by slot (at most
// MaxRadix slots, a rejected base drops the number), then the shared divider
// produces the digits least significant first, then one symbol per cycle goes
// out while the sink keeps up. number_ch is ready only when idle. reset clears
// the configuration registers, the sequencer and the output valid.
// a stalled sink holds the output register and the sequencer waits on it.
module signed_integer_to_radix_symbols_top import srs_pkg::*; #(
  parameter int MaxRadix = DEF_MAX_RADIX
) (
  input  logic                 clk,
  input  logic                 rst,
  srs_in_if.sink               number_ch,
  srs_out_if.source            symbol_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DigitW = $clog2(MaxRadix);
  localparam int IdxW   = $clog2(DIGIT_SLOTS);
  localparam int DepthW = $clog2(DIGIT_SLOTS + 1);

  state_t             state, state_next;
  logic [LEN_W-1:0]   base_length;
  logic [CFG_W-1:0]   symbols_low;
  logic [CFG_W-1:0]   symbols_high;

  logic               neg;
  logic [SLOT_W-1:0]  slot;
  logic [DepthW-1:0]  depth;
  logic [DepthW-1:0]  depth_m1;
  logic [DigitW-1:0]  stack [DIGIT_SLOTS];

  logic [NUM_W-1:0]   raw;
  logic [NUM_W-1:0]   mag;
  logic [DigitW:0]    radix;
  logic [NUM_W-1:0]   quot;
  logic [DigitW-1:0]  rem;
  logic               div_done;
  div_ctrl_t          div_ctrl;
  check_stat_t        chk;

  logic               in_ready;
  logic               slot_adv;
  logic               push;
  logic               emit_sign;
  logic               emit_digit;
  logic               out_free;
  logic               out_valid;
  logic [SYM_W-1:0]   out_symbol;
  logic               out_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_BASE_LENGTH:  base_length  <= cfg_data[LEN_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // magnitude of the incoming number
  assign raw   = number_ch.number;
  assign mag   = raw[NUM_W-1] ? (NUM_W'(0) - raw) : raw;
  assign radix = base_length[DigitW:0];

  srs_base_check #(.MaxRadix(MaxRadix)) u_check (
    .base_length  (base_length),
    .symbols_low  (symbols_low),
    .symbols_high (symbols_high),
    .slot         (slot),
    .stat         (chk)
  );

  srs_divider #(.MaxRadix(MaxRadix)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (mag),
    .radix    (radix),
    .quot     (quot),
    .rem      (rem),
    .done     (div_done)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign out_free = !out_valid || symbol_ch.ready;

  // sequencer
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_ctrl   = '0;
    slot_adv   = 1'b0;
    push       = 1'b0;
    emit_sign  = 1'b0;
    emit_digit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (number_ch.valid) begin
          div_ctrl.load = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk.bad)       state_next = ST_IDLE;
        else if (chk.last) state_next = ST_DIV;
        else               slot_adv   = 1'b1;
      end
      ST_DIV: begin
        div_ctrl.run = !(div_done && quot == '0);
        if (div_done) begin
          push = 1'b1;
          if (quot == '0) state_next = neg ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          emit_sign  = 1'b1;
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (out_free) begin
          emit_digit = 1'b1;
          if (depth == DepthW'(1)) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign depth_m1 = depth - 1'b1;

  // per-number control: sign, check slot, digit count
  always_ff @(posedge clk) begin
    if (rst) begin
      neg   <= 1'b0;
      slot  <= '0;
      depth <= '0;
    end else begin
      if (in_ready && number_ch.valid) begin
        neg   <= raw[NUM_W-1];
        slot  <= '0;
        depth <= '0;
      end else if (slot_adv) begin
        slot <= slot + 1'b1;
      end else if (push) begin
        depth <= depth + 1'b1;
      end else if (emit_digit) begin
        depth <= depth_m1;
      end
    end
  end

  // digit stack, least significant digit pushed first
  always_ff @(posedge clk) begin
    if (push) stack[depth[IdxW-1:0]] <= rem;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_sign || emit_digit) begin
      out_valid <= 1'b1;
    end else if (symbol_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_sign) begin
      out_symbol <= SIGN_MINUS;
      out_last   <= 1'b0;
    end else if (emit_digit) begin
      out_symbol <= symbol_of(symbols_low, symbols_high,
                              SLOT_W'(stack[depth_m1[IdxW-1:0]]));
      out_last   <= (depth == DepthW'(1));
    end
  end

  assign number_ch.ready  = in_ready;
  assign symbol_ch.valid  = out_valid;
  assign symbol_ch.symbol = out_symbol;
  assign symbol_ch.last   = out_last;

  // digit stack never overfills
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DepthW'(DIGIT_SLOTS))
    else $error("digit stack overfilled");

  // the digit state always has a digit left to send
  a_digits_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIGITS) |-> (depth != '0))
    else $error("digit state with an empty stack");

  // the divider finishes only while the sequencer waits on it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside division");

  // each finished digit is below the radix
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (div_done && state == ST_DIV) |-> ({1'b0, rem} < radix))
    else $error("digit not below radix");

endmodule

// ===== tb/sv/signed_integer_to_radix_symbols_top_test.sv =====
// self-checking testbench for the signed number to radix symbols converter
module signed_integer_to_radix_symbols_top_test;
  import srs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  // allowance for the slowest number, with margin
  localparam int LATENCY_WAIT   = 200;
  localparam int RANDOM_ITEMS   = 400;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [NUM_W-1:0] NUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [NUM_W-1:0] NUM_MIN = 32'sh8000_0000;

  // plain hex digit tables, digit k in byte k
  localparam logic [CFG_W-1:0] DIGITS_LO = "76543210";
  localparam logic [CFG_W-1:0] DIGITS_HI = "FEDCBA98";

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } symbol_req_t;

  typedef enum int {
    SINK_FLOWING,
    SINK_RANDOM,
    SINK_BURSTY
  } sink_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  srs_in_if  num_if ();
  srs_out_if sym_if ();

  signed_integer_to_radix_symbols_top dut (
    .clk       (clk),
    .rst       (rst),
    .number_ch (num_if),
    .symbol_ch (sym_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies as last written
  logic [LEN_W-1:0] model_len = '0;
  logic [CFG_W-1:0] model_lo  = '0;
  logic [CFG_W-1:0] model_hi  = '0;

  symbol_req_t expected_symbols[$];

  int fail_count    = 0;
  int numbers_sent  = 0;
  int valid_numbers = 0;
  int symbols_seen  = 0;
  int base_settings = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // symbol byte for a digit value under the current tables
  function automatic logic [SYM_W-1:0] table_symbol(input int unsigned digit);
    logic [CFG_W-1:0] word;
    word = (digit >= 8) ? model_hi : model_lo;
    return word[(digit % 8) * SYM_W +: SYM_W];
  endfunction

  // radix in range, no sign characters, no repeated symbols
  function automatic bit base_is_valid();
    int i, j;
    if (model_len < 2 || model_len > TABLE_SLOTS) return 1'b0;
    for (i = 0; i < model_len; i++) begin
      if (table_symbol(i) == SIGN_PLUS || table_symbol(i) == SIGN_MINUS) return 1'b0;
      for (j = i + 1; j < model_len; j++)
        if (table_symbol(i) == table_symbol(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queue the symbols one number turns into
  function automatic void expand_number(input logic signed [NUM_W-1:0] value);
    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] radix;
    int unsigned      digits[DIGIT_SLOTS];
    int               count;
    int               k;
    symbol_req_t      req;
    if (!base_is_valid()) return;
    mag = value;
    if (value[NUM_W-1]) mag = -mag;
    radix = NUM_W'(model_len);
    count = 0;
    if (mag == 0) begin
      digits[0] = 0;
      count = 1;
    end else begin
      while (mag != 0) begin
        digits[count] = mag % radix;
        mag = mag / radix;
        count++;
      end
    end
    if (value[NUM_W-1]) begin
      req.symbol = SIGN_MINUS;
      req.last   = 1'b0;
      expected_symbols.push_back(req);
    end
    for (k = count - 1; k >= 0; k--) begin
      req.symbol = table_symbol(digits[k]);
      req.last   = (k == 0);
      expected_symbols.push_back(req);
    end
  endfunction

  // mix of wide random values, small values, extremes and radix powers
  function automatic logic signed [NUM_W-1:0] pick_number();
    longint unsigned          p;
    int unsigned              radix;
    int                       k;
    logic signed [NUM_W-1:0]  v;
    radix = (model_len >= 2 && model_len <= TABLE_SLOTS) ? model_len : 10;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 40);
      1: v = 0 - $urandom_range(1, 40);
      2: begin
        case ($urandom_range(0, 3))
          0: v = NUM_MIN;
          1: v = NUM_MAX;
          2: v = 0;
          default: v = -1;
        endcase
      end
      3: begin
        p = 1;
        k = $urandom_range(1, 31);
        repeat (k) if (p * radix <= 64'h8000_0000) p = p * radix;
        v = p[NUM_W-1:0] + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // one register write, mirrored into the local copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_BASE_LENGTH:  model_len = data[LEN_W-1:0];
      REG_SYMBOLS_LOW:  model_lo  = data;
      REG_SYMBOLS_HIGH: model_hi  = data;
      default: ;
    endcase
  endtask

  // stop sending, let every symbol out, then allow for a silent number
  task automatic wait_until_idle();
    @(negedge clk);
    num_if.valid = 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic set_base(input logic [LEN_W-1:0] len, input logic [CFG_W-1:0] lo,
                          input logic [CFG_W-1:0] hi);
    wait_until_idle();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_BASE_LENGTH, len);
      write_reg(REG_SYMBOLS_LOW, lo);
      write_reg(REG_SYMBOLS_HIGH, hi);
    end else begin
      write_reg(REG_SYMBOLS_HIGH, hi);
      write_reg(REG_SYMBOLS_LOW, lo);
      write_reg(REG_BASE_LENGTH, len);
    end
    base_settings++;
  endtask

  // one number request, sent in bursts with random gaps between them
  task automatic send_number(input logic signed [NUM_W-1:0] value);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      num_if.valid  = 1'b0;
      num_if.number = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    num_if.valid  = 1'b1;
    num_if.number = value;
    @(posedge clk);
    while (!num_if.ready) @(posedge clk);
    numbers_sent++;
    if (base_is_valid()) valid_numbers++;
    expand_number(value);
  endtask

  // random distinct symbols, optionally broken in one way
  task automatic random_base(input bit make_bad);
    logic [SYM_W-1:0] slot_sym[TABLE_SLOTS];
    logic [255:0]     taken;
    logic [CFG_W-1:0] lo, hi;
    logic [SYM_W-1:0] pick;
    int               len, i, a, b;
    taken = '0;
    taken[SIGN_PLUS]  = 1'b1;
    taken[SIGN_MINUS] = 1'b1;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      do pick = $urandom_range(0, 255); while (taken[pick]);
      taken[pick] = 1'b1;
      slot_sym[i] = pick;
    end
    case ($urandom_range(0, 3))
      0: len = 2;
      1: len = TABLE_SLOTS;
      default: len = $urandom_range(2, TABLE_SLOTS);
    endcase
    if (make_bad) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 1);
        1: len = $urandom_range(TABLE_SLOTS + 1, 31);
        2: slot_sym[$urandom_range(0, len - 1)] = $urandom_range(0, 1) ? SIGN_PLUS : SIGN_MINUS;
        default: begin
          a = $urandom_range(0, len - 2);
          b = $urandom_range(a + 1, len - 1);
          slot_sym[b] = slot_sym[a];
        end
      endcase
    end else if (len < TABLE_SLOTS && $urandom_range(0, 3) == 0) begin
      // sign characters beyond the radix are harmless
      slot_sym[$urandom_range(len, TABLE_SLOTS - 1)] =
        $urandom_range(0, 1) ? SIGN_PLUS : SIGN_MINUS;
    end
    for (i = 0; i < TABLE_SLOTS; i++) begin
      if (i < 8) lo[i * SYM_W +: SYM_W] = slot_sym[i];
      else hi[(i - 8) * SYM_W +: SYM_W] = slot_sym[i];
    end
    set_base(LEN_W'(len), lo, hi);
  endtask

  // tables as they come out of reset: length zero, nothing emitted
  task automatic test_reset_base();
    send_number(0);
    send_number(-1);
  endtask

  // decimal with zero, sign and the extreme values
  task automatic test_decimal_and_extremes();
    set_base(10, DIGITS_LO, DIGITS_HI);
    send_number(0);
    send_number(7);
    send_number(-1);
    send_number(10);
    send_number(NUM_MAX);
    send_number(NUM_MIN);
    send_number(-32'sd1000000000);
  endtask

  // smallest and largest radix, including the longest run
  task automatic test_radix_limits();
    set_base(2, DIGITS_LO, DIGITS_HI);
    send_number(NUM_MIN);
    send_number(NUM_MAX);
    send_number(-1);
    send_number(0);
    set_base(16, DIGITS_LO, DIGITS_HI);
    send_number(NUM_MIN);
    send_number(NUM_MAX);
    send_number(-1);
    send_number(32'sh0123_ABCD);
  endtask

  // every way a base can be rejected
  task automatic test_invalid_bases();
    set_base(1, DIGITS_LO, DIGITS_HI);
    send_number(5);
    set_base(17, DIGITS_LO, DIGITS_HI);
    send_number(-5);
    set_base(31, DIGITS_LO, DIGITS_HI);
    send_number(NUM_MIN);
    set_base(10, "765+3210", DIGITS_HI);
    send_number(123);
    set_base(10, "7654321-", DIGITS_HI);
    send_number(-123);
    set_base(5, "76513210", DIGITS_HI);
    send_number(4);
    set_base(16, '1, '1);
    send_number(NUM_MAX);
  endtask

  // sign character past the radix, zero byte as a symbol, unused index
  task automatic test_symbol_corners();
    set_base(12, DIGITS_LO, "FED-BA98");
    send_number(-143);
    set_base(13, DIGITS_LO, "FED-BA98");
    send_number(143);
    set_base(8, {"7654321", 8'h00}, DIGITS_HI);
    send_number(0);
    send_number(64);
    send_number(-8);
    wait_until_idle();
    write_reg(REG_UNUSED, '1);
    send_number(9);
  endtask

  // random tables and numbers; rejected bases now and then
  task automatic test_random_bases();
    int start, n;
    start = valid_numbers;
    while (valid_numbers - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        random_base(1'b1);
        n = $urandom_range(1, 4);
      end else begin
        random_base(1'b0);
        n = $urandom_range(5, 40);
      end
      repeat (n) send_number(pick_number());
    end
  endtask

  // sink stalls on its own pattern
  initial begin
    sink_mode_t mode;
    int         mode_left;
    int         stall_left;
    mode       = SINK_FLOWING;
    mode_left  = 0;
    stall_left = 0;
    sym_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        SINK_FLOWING: sym_if.ready = 1'b1;
        SINK_RANDOM:  sym_if.ready = $urandom_range(0, 1);
        default: begin
          if (stall_left > 0) begin
            sym_if.ready = 1'b0;
            stall_left--;
          end else begin
            sym_if.ready = 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
          end
        end
      endcase
    end
  end

  // compare each symbol request with the oldest expectation
  always @(posedge clk) begin
    symbol_req_t want;
    if (!rst && sym_if.valid && sym_if.ready) begin
      symbols_seen++;
      if (expected_symbols.size() == 0) begin
        if (fail_count < 25)
          $display("%0t: unexpected symbol, expected none, got %h last %b",
                   $time, sym_if.symbol, sym_if.last);
        fail_count++;
      end else begin
        want = expected_symbols.pop_front();
        if (sym_if.symbol !== want.symbol) begin
          if (fail_count < 25)
            $display("%0t: symbol mismatch, expected %h, got %h",
                     $time, want.symbol, sym_if.symbol);
          fail_count++;
        end
        if (sym_if.last !== want.last) begin
          if (fail_count < 25)
            $display("%0t: last mismatch, expected %b, got %b",
                     $time, want.last, sym_if.last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any request
  always @(posedge clk) begin
    if (rst || (num_if.valid && num_if.ready) || (sym_if.valid && sym_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no request for %0d cycles, %0d symbols outstanding",
               $time, WATCHDOG_LIMIT, expected_symbols.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    rst           = 1'b1;
    num_if.valid  = 1'b0;
    num_if.number = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_BASE_LENGTH;
    cfg_data      = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_reset_base();
    test_decimal_and_extremes();
    test_radix_limits();
    test_invalid_bases();
    test_symbol_corners();
    test_random_bases();
    wait_until_idle();

    if (expected_symbols.size() != 0) begin
      $display("%0t: %0d expected symbols never arrived", $time, expected_symbols.size());
      fail_count++;
    end
    $display("%0d numbers sent, %0d of them under a usable base, %0d symbols checked",
             numbers_sent, valid_numbers, symbols_seen);
    $display("%0d base settings covering radix 2 to 16 and rejected tables", base_settings);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
